@@ src/assert_macros.svh @@
// Assertion macros shared by the serializer RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed: implication");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ src/sfs_pkg.sv @@
// Package for the spectrum frame serializer: constants, types and byte formatting
// functions. Depends on nothing.
`timescale 1ns / 1ps
package sfs_pkg;

  localparam int BANDS_PER_FRAME = 16;
  localparam int POS_W = (BANDS_PER_FRAME < 2) ? 1 : $clog2(BANDS_PER_FRAME);

  // Deepest burst one item produces: header, band byte and checksum.
  localparam int BURST_DEPTH = 8;
  localparam int CNT_W = $clog2(BURST_DEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
  localparam logic [7:0] START_FIRST_RST  = 8'd165;
  localparam logic [7:0] START_SECOND_RST = 8'd90;

  localparam logic signed [15:0] BAND_FULL_SCALE = 16'sd4096;
  localparam logic [23:0] TEMPO_SAT_LIMIT = 24'd1048560;  // 65535 tenths in Q.4
  localparam logic [15:0] TEMPO_MAX = 16'hFFFF;

  typedef struct packed {
    logic signed [15:0] band_level;
    logic               band_present;
    logic signed [20:0] beats_per_minute;
  } item_t;

  // Clamp a Q4.12 level to 0..1.0 and round it to 0..255.
  function automatic logic [7:0] band_to_byte(logic signed [15:0] lvl, logic present);
    logic [12:0] v;
    logic [20:0] p;
    if (lvl[15]) begin
      v = 13'd0;
    end else if (lvl > BAND_FULL_SCALE) begin
      v = 13'd4096;
    end else begin
      v = lvl[12:0];
    end
    p = {v, 8'd0} - {8'd0, v} + 21'd2048;
    return present ? p[19:12] : 8'd0;
  endfunction

  // Tempo in tenths of a BPM, rounded half up and saturated.
  function automatic logic [15:0] tempo_tenths(logic signed [20:0] bpm);
    logic [23:0] t;
    logic [23:0] r;
    t = {1'b0, bpm[19:0], 3'd0} + {3'd0, bpm[19:0], 1'b0};
    r = t + 24'd8;
    if (bpm[20] || (bpm == 21'sd0)) begin
      return 16'd0;
    end else if (t > TEMPO_SAT_LIMIT) begin
      return TEMPO_MAX;
    end else begin
      return r[19:4];
    end
  endfunction

endpackage

@@ src/spectrum_frame_serializer_unit.sv @@
// Spectrum frame serializer: turns band levels into a framed byte stream.
// Depends on sfs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
// An accepted item waits in the input register and moves to the byte buffer once the
// buffer is free; its first byte is then on the output straight from the buffer.
// Throughput: one byte leaves per cycle while out_ready is high, and an item makes
// 7 bytes for the first band of a frame, 1 for a middle band, 2 for the last band
// (8 when a frame holds a single band). The output byte port sets the pace.
// Reset (rst_n low, synchronous) empties the pipeline, clears the frame position,
// checksum and frame number, and restores the start byte registers.
`include "assert_macros.svh"
module spectrum_frame_serializer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                in_band_level,
  input  logic                              in_band_present,
  input  logic signed [20:0]                in_beats_per_minute,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_frame_byte,
  output logic                              out_frame_end,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                        cfg_data
);

  localparam int ND = sfs_pkg::BURST_DEPTH;
  localparam int CW = sfs_pkg::CNT_W;
  localparam int PW = sfs_pkg::POS_W;

  // Configuration registers. The user must write them only while the block is idle; the
  // block itself does not enforce this. Writes are always accepted.
  logic [7:0] start_first_r, start_second_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_first_r  <= sfs_pkg::START_FIRST_RST;
      start_second_r <= sfs_pkg::START_SECOND_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sfs_pkg::CFG_START_FIRST:  start_first_r  <= cfg_data;
        sfs_pkg::CFG_START_SECOND: start_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. It holds one raw word until the byte buffer can take all of
  // the bytes that word produces.
  sfs_pkg::item_t item_r;
  logic           item_vld_r;

  // Byte buffer: slot 0 is the byte on the output, later slots shift down one
  // per accepted output word.
  logic [7:0]    byte_r [ND];
  logic          end_r  [ND];
  logic [CW-1:0] cnt_r;

  // Frame state, updated when a word moves from the input register to the buffer.
  logic [PW-1:0] pos_r;
  logic [7:0]    sum_r;
  logic [15:0]   frame_num_r;

  logic pop, buf_free, load;

  assign out_valid      = (cnt_r != '0);
  assign out_frame_byte = byte_r[0];
  assign out_frame_end  = end_r[0];
  assign pop            = out_valid && out_ready;
  // The buffer can be refilled when empty or when its last byte leaves now.
  assign buf_free       = (cnt_r == '0) || ((cnt_r == CW'(1)) && pop);
  assign load           = item_vld_r && buf_free;
  assign in_ready       = !item_vld_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.band_level       <= in_band_level;
      item_r.band_present     <= in_band_present;
      item_r.beats_per_minute <= in_beats_per_minute;
    end
  end

  // Byte formatting for the word in the input register.
  logic          first, last;
  logic [7:0]    band_byte;
  logic [15:0]   tempo;
  logic [7:0]    hdr_sum, sum_base, chk;
  logic [7:0]    ld_byte [ND];
  logic          ld_end  [ND];
  logic [CW-1:0] ld_cnt;
  logic [PW-1:0] pos_nxt;
  logic [7:0]    sum_nxt;
  logic [15:0]   frame_num_nxt;

  always_comb begin
    first     = (pos_r == '0);
    last      = (pos_r == PW'(sfs_pkg::BANDS_PER_FRAME - 1));
    band_byte = sfs_pkg::band_to_byte(item_r.band_level, item_r.band_present);
    tempo     = sfs_pkg::tempo_tenths(item_r.beats_per_minute);
    hdr_sum   = frame_num_r[7:0] + frame_num_r[15:8] + tempo[7:0] + tempo[15:8];
    sum_base  = first ? hdr_sum : sum_r;
    chk       = sum_base + band_byte;

    for (int i = 0; i < ND; i++) begin
      ld_byte[i] = 8'd0;
      ld_end[i]  = 1'b0;
    end
    if (first) begin
      // Header, band byte and, for a one-band frame, the checksum as well.
      ld_byte[0] = start_first_r;
      ld_byte[1] = start_second_r;
      ld_byte[2] = frame_num_r[7:0];
      ld_byte[3] = frame_num_r[15:8];
      ld_byte[4] = tempo[7:0];
      ld_byte[5] = tempo[15:8];
      ld_byte[6] = band_byte;
      ld_byte[7] = chk;
      ld_end[7]  = 1'b1;
      ld_cnt     = last ? CW'(8) : CW'(7);
    end else begin
      ld_byte[0] = band_byte;
      ld_byte[1] = chk;
      ld_end[1]  = 1'b1;
      ld_cnt     = last ? CW'(2) : CW'(1);
    end

    pos_nxt       = last ? '0 : pos_r + PW'(1);
    sum_nxt       = last ? 8'd0 : chk;
    frame_num_nxt = first ? frame_num_r + 16'd1 : frame_num_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pos_r       <= '0;
      sum_r       <= 8'd0;
      frame_num_r <= 16'd0;
    end else if (load) begin
      cnt_r       <= ld_cnt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      frame_num_r <= frame_num_nxt;
    end else if (pop) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < ND; i++) begin
        byte_r[i] <= ld_byte[i];
        end_r[i]  <= ld_end[i];
      end
    end else if (pop) begin
      for (int i = 0; i < ND - 1; i++) begin
        byte_r[i] <= byte_r[i+1];
        end_r[i]  <= end_r[i+1];
      end
    end
  end

  // The buffer never claims more bytes than it has slots.
  `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(ND))
  // A checksum byte is always the last one in the buffer.
  `ASSERT_IMPLIES(a_end_last, clk, rst_n, out_valid && out_frame_end, cnt_r == CW'(1))
  // When the checksum is on the output the frame position has wrapped.
  `ASSERT_IMPLIES(a_end_wrap, clk, rst_n, out_valid && out_frame_end, pos_r == '0)
  // A refill always leaves bytes to send.
  `ASSERT_NEXT(a_load_fills, clk, rst_n, load, out_valid)

endmodule

@@ bench/tb_spectrum_frame_serializer_unit.sv @@
// Self-checking bench for spectrum_frame_serializer_unit: band level words in, framed bytes out.
// Depends on sfs_pkg for the item type and register indexes; reads no files.
`timescale 1ns / 1ps
module tb_spectrum_frame_serializer_unit;

  // Register indexes past the two real registers; writes to them must be ignored.
  localparam logic [sfs_pkg::CFG_IDX_W-1:0] CFG_SPARE_TWO   = 2'd2;
  localparam logic [sfs_pkg::CFG_IDX_W-1:0] CFG_SPARE_THREE = 2'd3;

  // Longest stretch without any word moving before the run is declared hung. The slowest
  // legal gap is a sender pause plus a receiver stall plus the pipeline, well under this.
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [7:0] frame_byte;
    logic       frame_end;
  } serial_byte_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic signed [15:0]             in_band_level = '0;
  logic                           in_band_present = 1'b0;
  logic signed [20:0]             in_beats_per_minute = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [7:0]                     out_frame_byte;
  logic                           out_frame_end;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [7:0]                     cfg_data = '0;

  spectrum_frame_serializer_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_band_level       (in_band_level),
    .in_band_present     (in_band_present),
    .in_beats_per_minute (in_beats_per_minute),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_byte      (out_frame_byte),
    .out_frame_end       (out_frame_end),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Band words waiting for the driver, and the bytes the serializer still owes us.
  sfs_pkg::item_t pending_items[$];
  serial_byte_t   bytes_due[$];

  // Our own copy of the start byte registers, kept in step with every accepted write.
  logic [7:0] marker_first  = sfs_pkg::START_FIRST_RST;
  logic [7:0] marker_second = sfs_pkg::START_SECOND_RST;

  // Frame tracking for the predictor: slot of the next band, checksum so far, frame count.
  int         band_slot   = 0;
  logic [7:0] frame_sum   = '0;
  logic [15:0] frame_count = '0;

  // Idle shaping, changed only between phases.
  int gap_max   = 0;
  int stall_pct = 0;

  int mismatches  = 0;
  int items_queued = 0;
  int random_frames = 0;

  // ---------------------------------------------------------------------------
  // Byte formatting, worked out independently of the package helpers.
  // ---------------------------------------------------------------------------

  // The level is clamped to 0..1.0 in Q4.12 and scaled to 0..255, rounding half up.
  // An absent band always goes out as zero.
  function automatic logic [7:0] band_code(logic signed [15:0] lvl, logic present);
    int v;
    int r;
    v = lvl;
    if (!present) return 8'd0;
    if (v < 0) v = 0;
    else if (v > 4096) v = 4096;
    r = (v * 255 + 2048) >> 12;
    return r[7:0];
  endfunction

  // Tempo arrives with four fraction bits and leaves as tenths of a BPM. Anything not
  // positive reports zero; anything past 65535 tenths pins at the top.
  function automatic logic [15:0] tempo_code(logic signed [20:0] bpm);
    int t;
    t = bpm;
    if (t <= 0) return 16'd0;
    t = t * 10;
    if (t > 65535 * 16) return 16'hFFFF;
    t = (t + 8) >> 4;
    return t[15:0];
  endfunction

  function automatic void owe_byte(logic [7:0] value, logic last);
    serial_byte_t b;
    b.frame_byte = value;
    b.frame_end  = last;
    bytes_due.push_back(b);
  endfunction

  // Append the bytes one accepted band word must produce. The opening band of a frame
  // carries the header; the closing band carries the checksum as well.
  task automatic predict_frame_bytes(logic signed [15:0] lvl, logic present,
                                     logic signed [20:0] bpm);
    logic [7:0]  band;
    logic [15:0] tenths;
    band = band_code(lvl, present);
    if (band_slot == 0) begin
      tenths = tempo_code(bpm);
      owe_byte(marker_first, 1'b0);
      owe_byte(marker_second, 1'b0);
      owe_byte(frame_count[7:0], 1'b0);
      owe_byte(frame_count[15:8], 1'b0);
      owe_byte(tenths[7:0], 1'b0);
      owe_byte(tenths[15:8], 1'b0);
      frame_sum = frame_count[7:0] + frame_count[15:8] + tenths[7:0] + tenths[15:8];
      frame_count = frame_count + 16'd1;
    end
    owe_byte(band, 1'b0);
    frame_sum = frame_sum + band;
    if (band_slot == sfs_pkg::BANDS_PER_FRAME - 1) begin
      owe_byte(frame_sum, 1'b1);
      band_slot = 0;
      frame_sum = '0;
    end else begin
      band_slot = band_slot + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Tempo values on the edges of the conversion: sign, zero, rounding, saturation.
  function automatic logic signed [20:0] tempo_corner(int k);
    case (k)
      0:       return 21'sd0;
      1:       return -21'sd1;
      2:       return 21'h100000;
      3:       return 21'sd1;
      4:       return 21'sd4;
      5:       return 21'sd3;
      6:       return 21'sd104856;
      7:       return 21'sd104857;
      8:       return 21'sd1048575;
      9:       return 21'sd1920;
      default: return 21'sd104855;
    endcase
  endfunction

  // Band levels around zero, full scale and the rounding steps.
  function automatic logic signed [15:0] level_corner(int k);
    case (k)
      0:       return 16'sd0;
      1:       return 16'sd1;
      2:       return -16'sd1;
      3:       return 16'h8000;
      4:       return 16'h7FFF;
      5:       return 16'sd4095;
      6:       return 16'sd4096;
      7:       return 16'sd4097;
      8:       return 16'sd2048;
      9:       return 16'sd8;
      10:      return 16'sd9;
      default: return 16'sd2047;
    endcase
  endfunction

  function automatic void add_item(logic signed [15:0] lvl, logic present,
                                   logic signed [20:0] bpm);
    sfs_pkg::item_t it;
    it.band_level       = lvl;
    it.band_present     = present;
    it.beats_per_minute = bpm;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  // Random band words. Frame openers get tempo corners first, then a mix of plausible
  // tempos, corners and raw bit patterns. Tempo on other bands is ignored by the block
  // but still randomized so every input bit toggles.
  function automatic void queue_random_items(int count);
    logic [31:0]        r;
    logic signed [15:0] lvl;
    logic signed [20:0] bpm;
    int                 sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      r = $urandom();
      if (sel < 35) begin
        r = $urandom_range(0, 4096);
        lvl = r[15:0];
      end else if (sel < 50) begin
        lvl = level_corner($urandom_range(0, 11));
      end else if (sel < 70) begin
        lvl = r[15:0];
      end else if (sel < 85) begin
        lvl = r[15:0] | 16'h8000;
      end else begin
        r = $urandom_range(4097, 32767);
        lvl = r[15:0];
      end
      r = $urandom();
      bpm = r[20:0];
      if (items_queued % sfs_pkg::BANDS_PER_FRAME == 0) begin
        sel = $urandom_range(0, 99);
        if (random_frames < 11) begin
          bpm = tempo_corner(random_frames);
        end else if (sel < 40) begin
          r = $urandom_range(0, 4000);
          bpm = r[20:0];
        end else if (sel < 70) begin
          bpm = tempo_corner($urandom_range(0, 10));
        end
        random_frames++;
      end
      add_item(lvl, $urandom_range(0, 9) != 0, bpm);
    end
  endfunction

  // One register write through the configuration channel; the mirror follows on acceptance.
  task automatic write_reg(logic [sfs_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sfs_pkg::CFG_START_FIRST:  marker_first  = value;
      sfs_pkg::CFG_START_SECOND: marker_second = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Sampled on the falling edge so that queue pops and valid updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || bytes_due.size() != 0);
  endtask

  task automatic run_phase(logic [7:0] first, logic [7:0] second, int gaps, int stalls,
                           int count);
    write_reg(sfs_pkg::CFG_START_FIRST, first);
    write_reg(sfs_pkg::CFG_START_SECOND, second);
    gap_max   = gaps;
    stall_pct = stalls;
    queue_random_items(count);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sender: drives band words in bursts of random length separated by random gaps.
  // The word on the pins is predicted at the edge where it is taken.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_items
    sfs_pkg::item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_frame_bytes(in_band_level, in_band_present, in_beats_per_minute);
      end
      // A new word may go up only when nothing is held on the pins.
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          in_valid            <= 1'b1;
          in_band_level       <= nxt.band_level;
          in_band_present     <= nxt.band_present;
          in_beats_per_minute <= nxt.beats_per_minute;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max == 0 || $urandom_range(0, 3) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, gap_max);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready most of the time, with stalls of random length dropped in at
  // the rate the current phase asks for.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 5);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every byte taken from the serializer must match the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_bytes
    serial_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bytes_due.size() == 0) begin
        $error("unexpected byte %02h (frame_end %0b) with nothing owed",
               out_frame_byte, out_frame_end);
        mismatches++;
      end else begin
        want = bytes_due.pop_front();
        if (out_frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %02h, got %02h", want.frame_byte, out_frame_byte);
          mismatches++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_frame_end);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a hung handshake or lost bytes show up as a long stretch of silence.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $error("no word moved for %0d cycles, %0d bytes still owed", IDLE_LIMIT,
               bytes_due.size());
        $display("spectrum_frame_serializer_unit regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frame at the reset start bytes: band levels on every clamp and rounding
    // edge, absent bands with large levels, and a saturating tempo on the opener. The
    // two extra words open the next frame with the most negative tempo, so the
    // position counter wraps and the frame number steps.
    add_item(16'sd0,      1'b1, 21'sd104857);
    add_item(16'sd1,      1'b1, -21'sd1);
    add_item(-16'sd1,     1'b1, 21'sd1048575);
    add_item(16'h8000,    1'b1, 21'h100000);
    add_item(16'h7FFF,    1'b1, 21'sd0);
    add_item(16'sd4096,   1'b1, 21'h0AAAAA);
    add_item(16'sd4097,   1'b1, 21'h155555);
    add_item(16'sd4095,   1'b1, 21'sd1920);
    add_item(16'sd2048,   1'b1, 21'sd4);
    add_item(16'sd8,      1'b1, 21'sd3);
    add_item(16'sd9,      1'b1, 21'sd1);
    add_item(16'h7FFF,    1'b0, 21'sd104856);
    add_item(-16'sd5,     1'b0, 21'sd104855);
    add_item(16'sd1000,   1'b1, 21'sd0);
    add_item(16'sd4096,   1'b0, -21'sd1);
    add_item(16'h5555,    1'b1, 21'sd12);
    add_item(16'h2AAA,    1'b1, 21'h100000);
    add_item(16'sd3000,   1'b1, 21'sd1600);
    wait_drained();

    // Writes to the indexes past the two registers must leave the start bytes alone.
    write_reg(CFG_SPARE_TWO, 8'h3C);
    write_reg(CFG_SPARE_THREE, 8'hC3);

    // Random phases across marker extremes and different idle mixes; one phase runs
    // with neither side ever pausing.
    run_phase(8'h00, 8'hFF, 3, 30, 120);
    run_phase(8'hFF, 8'h00, 0, 0, 100);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8, 50, 120);
    write_reg(CFG_SPARE_THREE, 8'($urandom_range(0, 255)));
    run_phase(sfs_pkg::START_FIRST_RST, sfs_pkg::START_SECOND_RST, 2, 15, 124);

    // Let any stray trailing byte surface before the verdict.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("spectrum_frame_serializer_unit regression: pass");
    end else begin
      $display("spectrum_frame_serializer_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/sfs_pkg.sv
src/spectrum_frame_serializer_unit.sv
bench/tb_spectrum_frame_serializer_unit.sv
